>>> rtl/core/art_pkg.sv
// Package: types, codes and defaults for the ack retransmit tracker.
`default_nettype none
package art_pkg;
    localparam int ENTRIES_DEF = 8;
    localparam logic [15:0] DELAY_RST = 16'd40;
    localparam logic [7:0]  LIMIT_RST = 8'd3;

    typedef enum logic [1:0] {
        CMD_TRACK = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        K_TRACKED = 3'd0,
        K_DUP     = 3'd1,
        K_NOCAP   = 3'd2,
        K_QFULL   = 3'd3,
        K_ACKED   = 3'd4,
        K_RETX    = 3'd5,
        K_TIMEOUT = 3'd6,
        K_RSVD    = 3'd7
    } t_kind;

    typedef enum logic {
        REG_DELAY = 1'b0,
        REG_LIMIT = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] device_id;
        logic [15:0] frame_crc;
        logic [3:0]  tx_free;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [63:0] peer_id;
        logic [15:0] peer_crc;
        logic [7:0]  attempt_count;
        logic        last;
    } t_out;
endpackage
`default_nettype wire

>>> rtl/core/art_if.sv
// Valid/ready channel interfaces.
`default_nettype none
interface art_in_if;
    logic               valid;
    logic               ready;
    art_pkg::t_in       data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface art_out_if;
    logic               valid;
    logic               ready;
    art_pkg::t_out      data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface art_cfg_if;
    logic               valid;
    logic               ready;
    logic [0:0]         index;
    logic [15:0]        wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> rtl/core/art_front.sv
// Front: two-entry queue of input beats toward the engine.
`default_nettype none
module art_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    art_in_if.sink          s_in,
    output art_pkg::t_in    o_item,
    output logic            o_item_valid,
    input  wire             i_item_pop
);
    import art_pkg::*;

    t_in        r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    assign s_in.ready   = (r_cnt != 2'd2);
    assign push         = s_in.valid && s_in.ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = i_item_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_item_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp] <= s_in.data;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/art_engine.sv
// Back end: table of pending frames, one slot examined per cycle unless the output stalls the scan.
`default_nettype none
module art_engine #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  art_pkg::t_in    i_item,
    input  wire             i_item_valid,
    output logic            o_item_pop,
    art_cfg_if.sink         s_cfg,
    art_out_if.source       m_out
);
    import art_pkg::*;

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_state           r_st, n_st;
    logic [ENTRIES-1:0] r_act, n_act;
    logic [63:0]      r_dev [ENTRIES];
    logic [15:0]      r_crc [ENTRIES];
    logic [31:0]      r_dl  [ENTRIES];
    logic [7:0]       r_att [ENTRIES];
    logic [31:0]      r_now, n_now;
    logic [15:0]      r_delay;
    logic [7:0]       r_limit;
    t_in              r_it, n_it;
    logic [SW-1:0]    r_idx, n_idx;
    logic [3:0]       r_room, n_room;
    logic [3:0]       r_nout, n_nout;
    logic             r_free_ok, n_free_ok;
    logic [SW-1:0]    r_free, n_free;
    t_out             r_out, n_out;
    logic             r_ovalid, n_ovalid;
    t_out             r_pend, n_pend;
    logic             r_pv, n_pv;

    logic             hit, due, at_end, free_ok, out_free;
    logic             found, fin, rep, stall;
    logic             wr_new, wr_att, wr_dl;
    logic [SW-1:0]    free_c;
    logic [31:0]      diff, dl_val;
    logic [7:0]       att_inc;
    logic [23:0]      prod;
    t_out             res;

    assign s_cfg.ready = 1'b1;
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    assign hit      = r_act[r_idx] && r_dev[r_idx] == r_it.device_id
                      && r_crc[r_idx] == r_it.frame_crc;
    assign diff     = r_now - r_dl[r_idx];
    assign due      = r_act[r_idx] && !diff[31];
    assign at_end   = (32'(r_idx) == 32'(ENTRIES - 1));
    assign att_inc  = r_att[r_idx] + 8'd1;
    assign prod     = {16'd0, att_inc} * {8'd0, r_delay};
    assign free_ok  = r_free_ok || !r_act[r_idx];
    assign free_c   = r_free_ok ? r_free : r_idx;
    assign out_free = !r_ovalid || m_out.ready;

    always_comb begin
        n_st = r_st; n_act = r_act; n_now = r_now; n_it = r_it;
        n_idx = r_idx; n_room = r_room; n_nout = r_nout;
        n_free_ok = r_free_ok; n_free = r_free;
        n_out = r_out; n_ovalid = r_ovalid; n_pend = r_pend; n_pv = r_pv;
        o_item_pop = 1'b0;
        found = 1'b0; fin = 1'b0; rep = 1'b0; stall = 1'b0;
        wr_new = 1'b0; wr_att = 1'b0; wr_dl = 1'b0; dl_val = '0;
        res = '0;
        if (m_out.valid && m_out.ready) n_ovalid = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_it = i_item; n_idx = '0; n_room = i_item.tx_free;
                    n_nout = '0; n_free_ok = 1'b0; n_pv = 1'b0;
                    if (i_item.cmd == CMD_TICK) n_now = r_now + 32'd1;
                    if (i_item.cmd != CMD_NONE) n_st = ST_SCAN;
                end
            end
            ST_SCAN: begin
                res.slot = 3'(r_idx);
                res.peer_id = r_dev[r_idx];
                res.peer_crc = r_crc[r_idx];
                res.attempt_count = r_att[r_idx];
                priority case (r_it.cmd)
                    CMD_TRACK: begin
                        n_free_ok = free_ok; n_free = free_c;
                        if (hit) begin
                            found = 1'b1; fin = 1'b1; res.kind = K_DUP;
                        end else if (at_end) begin
                            found = 1'b1; fin = 1'b1;
                            res.peer_id = r_it.device_id;
                            res.peer_crc = r_it.frame_crc;
                            res.attempt_count = 8'd0;
                            if (!free_ok) begin
                                res.kind = K_NOCAP; res.slot = 3'd0;
                            end else begin
                                res.slot = 3'(free_c);
                                if (r_it.tx_free == 4'd0) begin
                                    res.kind = K_QFULL;
                                end else begin
                                    res.kind = K_TRACKED;
                                    res.attempt_count = 8'd1;
                                    wr_new = 1'b1;
                                    n_act[free_c] = 1'b1;
                                end
                            end
                        end
                    end
                    CMD_ACK: begin
                        if (hit) begin
                            found = 1'b1; fin = 1'b1; res.kind = K_ACKED;
                            n_act[r_idx] = 1'b0;
                        end else if (at_end) begin
                            fin = 1'b1;
                        end
                    end
                    default: begin
                        if (at_end) fin = 1'b1;
                        if (due) begin
                            if (r_att[r_idx] >= r_limit) begin
                                found = 1'b1; res.kind = K_TIMEOUT;
                                n_act[r_idx] = 1'b0;
                            end else if (r_room != 4'd0) begin
                                found = 1'b1; res.kind = K_RETX;
                                res.attempt_count = att_inc;
                                n_room = r_room - 4'd1;
                                wr_att = 1'b1; wr_dl = 1'b1;
                                dl_val = r_now + 32'(prod);
                            end else begin
                                wr_dl = 1'b1;
                                dl_val = r_now + 32'(r_delay);
                            end
                        end
                    end
                endcase
                rep = found && (r_nout < 4'd8);
                stall = rep && r_pv && !out_free;
                if (stall) begin
                    // earlier result still waits for the output register
                    n_act = r_act; n_room = r_room;
                    n_free_ok = r_free_ok; n_free = r_free;
                    wr_new = 1'b0; wr_att = 1'b0; wr_dl = 1'b0;
                end else begin
                    if (rep) begin
                        if (r_pv) begin
                            n_out = r_pend; n_ovalid = 1'b1;
                        end
                        n_pend = res; n_pv = 1'b1; n_nout = r_nout + 4'd1;
                    end
                    if (fin) n_st = (rep || r_pv) ? ST_EMIT : ST_IDLE;
                    else n_idx = r_idx + SW'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out = r_pend; n_out.last = 1'b1;
                    n_ovalid = 1'b1; n_pv = 1'b0;
                    n_st = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_act <= '0; r_now <= '0;
            r_delay <= DELAY_RST; r_limit <= LIMIT_RST;
            r_ovalid <= 1'b0; r_pv <= 1'b0;
            r_nout <= '0; r_free_ok <= 1'b0; r_idx <= '0;
        end else begin
            r_st <= n_st; r_act <= n_act; r_now <= n_now;
            r_ovalid <= n_ovalid; r_pv <= n_pv;
            r_nout <= n_nout; r_free_ok <= n_free_ok; r_idx <= n_idx;
            if (s_cfg.valid && s_cfg.ready) begin
                if (s_cfg.index == REG_DELAY) r_delay <= s_cfg.wdata;
                else r_limit <= s_cfg.wdata[7:0];
            end
        end
        r_it <= n_it; r_room <= n_room; r_free <= n_free;
        r_out <= n_out; r_pend <= n_pend;
        if (wr_new) begin
            r_dev[free_c] <= r_it.device_id;
            r_crc[free_c] <= r_it.frame_crc;
            r_att[free_c] <= 8'd1;
            r_dl[free_c]  <= r_now + 32'(r_delay);
        end
        if (wr_att) r_att[r_idx] <= att_inc;
        if (wr_dl) r_dl[r_idx] <= dl_val;
    end
endmodule
`default_nettype wire

>>> rtl/core/ack_retransmit_tracker.sv
// Top level of the ack retransmit tracker.
// Tracks up to ENTRIES frames awaiting acknowledgement. Items go through a
// two-beat queue into an engine that examines one table slot per cycle
// unless a stall holds the scan. The engine takes the item, scans the slots
// in order (track and ack stop at the first match) and then sends the final
// result, if there is one. A result is held back in a pending register so it
// can carry the last flag; when the next result of the same tick finds the
// output register still occupied, the scan waits for it. Results leave
// through a registered output. The table is cleared at reset. Write
// configuration only while idle.
`default_nettype none
module ack_retransmit_tracker #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    art_in_if.sink  s_in,
    art_cfg_if.sink s_cfg,
    art_out_if.source m_out
);
    import art_pkg::*;

    t_in  item;
    logic item_valid, item_pop;

    art_front u_front (
        .i_clk, .i_rst_n, .s_in,
        .o_item(item), .o_item_valid(item_valid), .i_item_pop(item_pop)
    );

    art_engine #(.ENTRIES(ENTRIES)) u_engine (
        .i_clk, .i_rst_n,
        .i_item(item), .i_item_valid(item_valid), .o_item_pop(item_pop),
        .s_cfg, .m_out
    );
endmodule
`default_nettype wire

>>> sim/art_tb_if.sv
// Testbench-side note: channel interfaces come from the RTL; this file holds the beat record type.
`timescale 1ns / 1ps
package art_tb_pkg;
    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [63:0] peer_id;
        logic [15:0] peer_crc;
        logic [7:0]  attempt_count;
        logic        last;
    } t_exp;
endpackage

>>> sim/art_checker.sv
// Checker: predicts tracker results from accepted beats and compares them.
`timescale 1ns / 1ps
module art_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    art_in_if.sink      s_in,
    art_cfg_if.sink     s_cfg,
    art_out_if.sink     s_out,
    output int          o_fail_count,
    output int          o_pending
);
    import art_pkg::*;
    import art_tb_pkg::*;

    localparam int NSLOT = 8;

    logic [15:0] delay_ms;
    logic [7:0]  limit;
    logic        act [NSLOT];
    logic [63:0] dev [NSLOT];
    logic [15:0] crc [NSLOT];
    logic [31:0] due_at [NSLOT];
    logic [7:0]  tries [NSLOT];
    logic [31:0] now_ms;
    t_exp        expected_q [$];

    assign o_pending = expected_q.size();

    function automatic t_exp mk(logic [2:0] k, int s, logic [63:0] id, logic [15:0] c,
                                logic [7:0] a);
        t_exp e;
        e.kind = k;
        e.slot = s[2:0];
        e.peer_id = id;
        e.peer_crc = c;
        e.attempt_count = a;
        e.last = 1'b0;
        return e;
    endfunction

    task automatic predict_item(t_in it);
        t_exp res [$];
        int free_slot;
        int room;
        logic [31:0] diff;
        bit hit;
        free_slot = -1;
        hit = 0;
        case (it.cmd)
            CMD_TRACK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!hit && act[i] && dev[i] == it.device_id && crc[i] == it.frame_crc) begin
                        res.push_back(mk(K_DUP, i, it.device_id, it.frame_crc, tries[i]));
                        hit = 1;
                    end
                end
                if (!hit) begin
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!act[i]) free_slot = i;
                    if (free_slot < 0) begin
                        res.push_back(mk(K_NOCAP, 0, it.device_id, it.frame_crc, 8'd0));
                    end else if (it.tx_free == 0) begin
                        res.push_back(mk(K_QFULL, free_slot, it.device_id, it.frame_crc, 8'd0));
                    end else begin
                        act[free_slot] = 1;
                        dev[free_slot] = it.device_id;
                        crc[free_slot] = it.frame_crc;
                        tries[free_slot] = 8'd1;
                        due_at[free_slot] = now_ms + 32'(delay_ms);
                        res.push_back(mk(K_TRACKED, free_slot, it.device_id, it.frame_crc, 8'd1));
                    end
                end
            end
            CMD_ACK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!hit && act[i] && dev[i] == it.device_id && crc[i] == it.frame_crc) begin
                        act[i] = 0;
                        res.push_back(mk(K_ACKED, i, it.device_id, it.frame_crc, tries[i]));
                        hit = 1;
                    end
                end
            end
            CMD_TICK: begin
                room = it.tx_free;
                now_ms = now_ms + 32'd1;
                for (int i = 0; i < NSLOT; i++) begin
                    diff = now_ms - due_at[i];
                    if (act[i] && !diff[31]) begin
                        if (tries[i] >= limit) begin
                            act[i] = 0;
                            res.push_back(mk(K_TIMEOUT, i, dev[i], crc[i], tries[i]));
                        end else if (room > 0) begin
                            room--;
                            tries[i] = tries[i] + 8'd1;
                            due_at[i] = now_ms + 32'(tries[i]) * 32'(delay_ms);
                            res.push_back(mk(K_RETX, i, dev[i], crc[i], tries[i]));
                        end else begin
                            due_at[i] = now_ms + 32'(delay_ms);
                        end
                    end
                end
            end
            default: ;
        endcase
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[j]) expected_q.push_back(res[j]);
    endtask

    always @(posedge i_clk) begin
        t_exp e;
        t_out got;
        if (!i_rst_n) begin
            delay_ms <= DELAY_RST;
            limit <= LIMIT_RST;
            for (int i = 0; i < NSLOT; i++) begin
                act[i] = 0;
                dev[i] = '0;
                crc[i] = '0;
                due_at[i] = '0;
                tries[i] = '0;
            end
            now_ms = '0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (s_cfg.valid && s_cfg.ready) begin
                if (t_reg'(s_cfg.index) == REG_DELAY) delay_ms <= s_cfg.wdata;
                else limit <= s_cfg.wdata[7:0];
            end
            if (s_in.valid && s_in.ready) predict_item(s_in.data);
            if (s_out.valid && s_out.ready) begin
                got = s_out.data;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat kind=%0d slot=%0d", got.kind, got.slot);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (got.kind !== e.kind || got.slot !== e.slot || got.peer_id !== e.peer_id
                        || got.peer_crc !== e.peer_crc || got.attempt_count !== e.attempt_count
                        || got.last !== e.last) begin
                        if (o_fail_count < 10)
                            $display("mismatch exp k%0d s%0d id%h c%h a%0d l%0d got k%0d s%0d id%h c%h a%0d l%0d",
                                e.kind, e.slot, e.peer_id, e.peer_crc, e.attempt_count, e.last,
                                got.kind, got.slot, got.peer_id, got.peer_crc,
                                got.attempt_count, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> sim/ack_retransmit_tracker_tb.sv
// Testbench top: drives tracker stimulus and configuration, reports the verdict.
`timescale 1ns / 1ps
module ack_retransmit_tracker_tb;
    import art_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #5 i_clk = ~i_clk;

    art_in_if  in_ch ();
    art_cfg_if cfg_ch ();
    art_out_if out_ch ();

    int fail_count;
    int pending;
    int idle_pct_in = 25;
    int idle_pct_out = 25;
    bit hold_off = 0;
    int quiet = 0;
    logic [63:0] key_id [4];
    logic [15:0] key_crc [4];

    ack_retransmit_tracker i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .s_cfg(cfg_ch.sink),
        .m_out(out_ch.source)
    );

    art_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .s_cfg(cfg_ch.sink),
        .s_out(out_ch.sink), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        cfg_ch.valid = 0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 0;
        else out_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct_out);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays high after a beat; next call or caller reuses or drops it
    task automatic send(t_cmd c, logic [63:0] id, logic [15:0] cr, logic [3:0] txf);
        while ($urandom_range(99) < idle_pct_in) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= '{cmd: c, device_id: id, frame_crc: cr, tx_free: txf};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [15:0] v);
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        cfg_ch.valid <= 1;
        cfg_ch.index <= r;
        cfg_ch.wdata <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic random_phase(int n);
        int k;
        int r;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(3);
            r = $urandom_range(99);
            if (r < 35) send(CMD_TRACK, key_id[k], key_crc[k], 4'($urandom));
            else if (r < 55) send(CMD_ACK, key_id[k], key_crc[k], 4'($urandom));
            else if (r < 90) send(CMD_TICK, {$urandom, $urandom}, 16'($urandom),
                                  4'($urandom_range(3)));
            else if (r < 95) send(t_cmd'(2'($urandom)), {$urandom, $urandom}, 16'($urandom),
                                  4'($urandom));
            else send(CMD_NONE, {$urandom, $urandom}, 16'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < 4; i++) begin
            key_id[i] = {$urandom, $urandom};
            key_crc[i] = 16'($urandom);
        end
        key_id[0] = '1;
        key_crc[0] = '1;
        key_id[1] = '0;
        key_crc[1] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        idle_pct_in = 0;
        idle_pct_out = 0;
        // directed: fill, duplicate, no capacity, queue full, ack, ticks
        send(CMD_TRACK, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'hF);
        send(CMD_TRACK, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'h1);
        send(CMD_TRACK, 64'h0, 16'h0, 4'h0);
        for (int i = 0; i < 8; i++) send(CMD_TRACK, 64'(i), 16'(i * 3), 4'hF);
        send(CMD_ACK, 64'h0, 16'h0, 4'h0);
        send(CMD_ACK, 64'h0, 16'h0, 4'h0);
        send(CMD_ACK, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'h0);
        send(CMD_NONE, 64'h5, 16'h5, 4'h5);
        write_reg(REG_DELAY, 16'd1);
        write_reg(REG_LIMIT, 16'd2);
        send(CMD_TICK, '0, '0, 4'h1);
        send(CMD_TICK, '0, '0, 4'h0);
        send(CMD_TICK, '0, '0, 4'hF);
        for (int i = 0; i < 5; i++) send(CMD_TICK, '0, '0, 4'hF);
        write_reg(REG_LIMIT, 16'd255);
        write_reg(REG_DELAY, 16'd65535);
        idle_pct_in = 25;
        idle_pct_out = 25;
        random_phase(40);
        write_reg(REG_DELAY, 16'd2);
        write_reg(REG_LIMIT, 16'd1);
        random_phase(40);
        write_reg(REG_DELAY, 16'd3);
        write_reg(REG_LIMIT, 16'd4);
        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                random_phase(30);
                in_ch.valid <= 0;
            end
        join
        idle_pct_in = 0;
        idle_pct_out = 0;
        random_phase(40);
        idle_pct_in = 25;
        idle_pct_out = 25;
        write_reg(REG_DELAY, 16'd1);
        write_reg(REG_LIMIT, 16'd3);
        random_phase(60);
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

>>> ack_retransmit_tracker.f
rtl/core/art_pkg.sv
rtl/core/art_if.sv
rtl/core/art_front.sv
rtl/core/art_engine.sv
rtl/core/ack_retransmit_tracker.sv
sim/art_tb_if.sv
sim/art_checker.sv
sim/ack_retransmit_tracker_tb.sv
